// File: rtl/core/html_entity_decoder_defines.svh
// Assertion macros used by the checker module of the entity decoder.
`ifndef HTML_ENTITY_DECODER_DEFINES_SVH
`define HTML_ENTITY_DECODER_DEFINES_SVH

// Property that is checked only while reset is released.
`define HED_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that is checked at every edge, reset cycles included.
`define HED_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/hed_pkg.sv
// Shared types, character codes and the entity name table of the entity decoder.
package hed_pkg;

  // Sizing of the decoder.
  localparam int MAX_BODY_LEN  = 32;
  localparam int NAME_CHARS    = 7;
  localparam int TABLE_ENTRIES = 76;
  localparam int KEY_W         = NAME_CHARS * 8;
  localparam int CP_W          = 32;
  localparam int ADV_W         = 6;
  localparam int TCP_W         = 16;

  // Characters with a special meaning inside a reference.
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_X    = 8'h78;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LF   = 8'h66;
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UF   = 8'h46;

  // Code point given back for a rejected reference, and the saturated value of the numeric parser.
  localparam logic [CP_W-1:0] CP_AMP = 32'h0000_0026;
  localparam logic [CP_W-1:0] CP_MAX = 32'hFFFF_FFFF;

  // Form of the reference body seen so far.
  typedef enum logic [2:0] {
    FORM_NONE = 3'd0,
    FORM_HASH = 3'd1,
    FORM_HEX  = 3'd2,
    FORM_DEC  = 3'd3,
    FORM_NAME = 3'd4
  } form_t;

  // Running state of the numeric parser.
  typedef struct packed {
    logic [CP_W-1:0] value;
    logic            saturated;
    logic            stopped;
  } num_state_t;

  // Outcome of a name table search.
  typedef struct packed {
    logic             hit;
    logic [TCP_W-1:0] code;
  } lookup_t;

  // Entity names, packed first character highest and right aligned.
  localparam logic [KEY_W-1:0] NAME_KEYS [TABLE_ENTRIES] = '{
    "Cfr", "Copf", "DD", "Escr", "Fscr", "Hfr", "Hopf", "Lscr",
    "Mscr", "Nopf", "Popf", "Qopf", "Ropf", "Rscr", "Zfr", "Zopf",
    "alefsym", "amp", "apos", "bernou", "beth", "cent", "check", "clubs",
    "commat", "copy", "copysr", "cross", "daleth", "dd", "diams", "ee",
    "ell", "escr", "euro", "female", "flat", "gimel", "gscr", "gt",
    "hamlit", "hearts", "ii", "iiota", "image", "incare", "lbbrk", "lscr",
    "lt", "male", "malt", "mho", "natural", "nbsp", "numero", "oscr",
    "para", "phone", "planck", "planckh", "pound", "quot", "rbbrk", "real",
    "reg", "rx", "sect", "sext", "sharp", "spades", "star", "starf",
    "sung", "trade", "weierp", "yen"
  };

  // Code points in the same order as the names.
  localparam logic [TCP_W-1:0] NAME_CODES [TABLE_ENTRIES] = '{
    16'h212D, 16'h2102, 16'h2145, 16'h2130, 16'h2131, 16'h210C, 16'h210D, 16'h2112,
    16'h2133, 16'h2115, 16'h2119, 16'h211A, 16'h211D, 16'h211B, 16'h2128, 16'h2124,
    16'h2135, 16'h0026, 16'h0027, 16'h212C, 16'h2136, 16'h00A2, 16'h2713, 16'h2663,
    16'h0040, 16'h00A9, 16'h2117, 16'h2717, 16'h2138, 16'h2146, 16'h2666, 16'h2147,
    16'h2113, 16'h212F, 16'h20AC, 16'h2640, 16'h266D, 16'h2137, 16'h210A, 16'h003E,
    16'h210B, 16'h2665, 16'h2148, 16'h2129, 16'h2111, 16'h2105, 16'h2772, 16'h2110,
    16'h003C, 16'h2642, 16'h2720, 16'h2127, 16'h266E, 16'h00A0, 16'h2116, 16'h2134,
    16'h00B6, 16'h260E, 16'h210F, 16'h210E, 16'h00A3, 16'h0022, 16'h2773, 16'h211C,
    16'h00AE, 16'h211E, 16'h00A7, 16'h2736, 16'h266F, 16'h2660, 16'h2606, 16'h2605,
    16'h266A, 16'h2122, 16'h2118, 16'h00A5
  };

endpackage

// File: rtl/core/html_entity_decoder.sv
// Top level of the HTML character reference decoder.
//
//  Channel | Direction | Payload
//  --------+-----------+--------------------------------------------------
//  in_     | slave     | tdata[7:0] byte after the ampersand
//  out_    | master    | tdata code_point and advance, tuser accepted flag
//
// One byte is taken every cycle unless a stalled result holds the block; the byte
// that closes or rejects the reference passes the input register, then the result register.
// The per-byte work is one digit step of the numeric parser or one name shift,
// plus a parallel compare against the 76-entry name table at the ';'.
// Reset clears the input, parser and result valid state at once.
// A stalled result holds the block only when the next byte also makes a result.
module html_entity_decoder
  import hed_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] code_point, [37:32] advance, [39:38] zero
  output logic        out_tuser   // [0] accepted
);

  // Input register.
  logic       in_vld_r;
  logic [7:0] in_ch_r;

  // Parser state.
  logic [ADV_W-1:0] byte_count_r, byte_count_nxt;
  form_t            form_r, form_nxt;
  logic [KEY_W-1:0] name_key_r, name_key_nxt;
  logic             name_long_r, name_long_nxt;
  num_state_t       num_r, num_nxt, num_step;

  // Result register.
  logic             out_vld_r;
  logic [CP_W-1:0]  out_cp_r, out_cp_nxt;
  logic [ADV_W-1:0] out_adv_r, out_adv_nxt;
  logic             out_acc_r, out_acc_nxt;

  logic    is_nul, is_semi, body_full, emit, fire;
  lookup_t look;

  // Shared units.
  hed_numeric u_num (
    .ch  (in_ch_r),
    .hex (form_r == FORM_HEX),
    .cur (num_r),
    .nxt (num_step)
  );

  hed_lookup u_look (
    .key (name_key_r),
    .res (look)
  );

  // A byte moves on unless it makes a result that has nowhere to go.
  assign is_nul    = (in_ch_r == CH_NUL);
  assign is_semi   = (in_ch_r == CH_SEMI);
  assign body_full = (byte_count_r >= ADV_W'(MAX_BODY_LEN));
  assign emit      = is_nul || is_semi || body_full;
  assign fire      = in_vld_r && (!emit || !out_vld_r || out_tready);
  assign in_tready = !in_vld_r || fire;

  // Input register load.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      in_ch_r <= in_tdata;
    end
  end

  // Next parser state and the result of the current byte.
  always_comb begin
    byte_count_nxt = byte_count_r;
    form_nxt       = form_r;
    name_key_nxt   = name_key_r;
    name_long_nxt  = name_long_r;
    num_nxt        = num_r;
    out_cp_nxt     = CP_AMP;
    out_adv_nxt    = ADV_W'(1);
    out_acc_nxt    = 1'b0;
    if (emit) begin
      // Every result returns the parser to its reset state.
      byte_count_nxt = '0;
      form_nxt       = FORM_NONE;
      name_key_nxt   = '0;
      name_long_nxt  = 1'b0;
      num_nxt        = '0;
      if (!is_nul && is_semi) begin
        unique case (form_r)
          FORM_HASH, FORM_HEX, FORM_DEC: begin
            out_cp_nxt  = num_r.value;
            out_adv_nxt = ADV_W'(byte_count_r + ADV_W'(2));
            out_acc_nxt = 1'b1;
          end
          FORM_NAME: begin
            if (!name_long_r && look.hit) begin
              out_cp_nxt  = {{(CP_W-TCP_W){1'b0}}, look.code};
              out_adv_nxt = ADV_W'(byte_count_r + ADV_W'(2));
              out_acc_nxt = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end else begin
      byte_count_nxt = ADV_W'(byte_count_r + ADV_W'(1));
      unique case (form_r)
        FORM_NONE, FORM_NAME: begin
          if (form_r == FORM_NONE && in_ch_r == CH_HASH) begin
            form_nxt = FORM_HASH;
          end else begin
            form_nxt = FORM_NAME;
            if (byte_count_r < ADV_W'(NAME_CHARS)) begin
              name_key_nxt = {name_key_r[KEY_W-9:0], in_ch_r};
            end else begin
              name_long_nxt = 1'b1;
            end
          end
        end
        FORM_HASH: begin
          if (in_ch_r == CH_X) begin
            form_nxt = FORM_HEX;
          end else begin
            form_nxt = FORM_DEC;
            num_nxt  = num_step;
          end
        end
        FORM_HEX, FORM_DEC: begin
          num_nxt = num_step;
        end
        default: begin
        end
      endcase
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      form_r       <= FORM_NONE;
      name_key_r   <= '0;
      name_long_r  <= 1'b0;
      num_r        <= '0;
    end else if (fire) begin
      byte_count_r <= byte_count_nxt;
      form_r       <= form_nxt;
      name_key_r   <= name_key_nxt;
      name_long_r  <= name_long_nxt;
      num_r        <= num_nxt;
    end
  end

  // Result register; a new result may replace one being taken this cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire && emit) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
    if (fire && emit) begin
      out_cp_r  <= out_cp_nxt;
      out_adv_r <= out_adv_nxt;
      out_acc_r <= out_acc_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, out_adv_r, out_cp_r};
  assign out_tuser  = out_acc_r;

endmodule

// File: rtl/core/hed_numeric.sv
// One digit step of the numeric parser: multiply by the base, add, saturate.
module hed_numeric
  import hed_pkg::*;
(
  input  logic       [7:0] ch,
  input  logic             hex,
  input  num_state_t       cur,
  output num_state_t       nxt
);

  logic [3:0]      dig;
  logic            dig_ok;
  logic [CP_W+3:0] prod;
  logic [CP_W+3:0] sum;

  // Digit decode; letters count only in hexadecimal.
  always_comb begin
    dig    = 4'd0;
    dig_ok = 1'b0;
    if (ch >= CH_0 && ch <= CH_9) begin
      dig    = 4'(ch - CH_0);
      dig_ok = 1'b1;
    end else if (hex && ch >= CH_LA && ch <= CH_LF) begin
      dig    = 4'(ch - CH_LA + 8'd10);
      dig_ok = 1'b1;
    end else if (hex && ch >= CH_UA && ch <= CH_UF) begin
      dig    = 4'(ch - CH_UA + 8'd10);
      dig_ok = 1'b1;
    end
  end

  // Times sixteen is a shift; times ten is eight plus two.
  always_comb begin
    if (hex) begin
      prod = {cur.value, 4'b0000};
    end else begin
      prod = {1'b0, cur.value, 3'b000} + {3'b000, cur.value, 1'b0};
    end
    sum = prod + {{CP_W{1'b0}}, dig};
  end

  // Accumulate until the first non-digit; hold once saturated.
  always_comb begin
    nxt = cur;
    if (!cur.stopped) begin
      if (!dig_ok) begin
        nxt.stopped = 1'b1;
      end else if (!cur.saturated) begin
        if (sum[CP_W+3:CP_W] != 4'd0) begin
          nxt.value     = CP_MAX;
          nxt.saturated = 1'b1;
        end else begin
          nxt.value = sum[CP_W-1:0];
        end
      end
    end
  end

endmodule

// File: rtl/core/hed_lookup.sv
// Parallel search of the entity name table for the collected name.
module hed_lookup
  import hed_pkg::*;
(
  input  logic [KEY_W-1:0] key,
  output lookup_t          res
);

  // Every entry is compared at once; names are unique, the first hit wins.
  always_comb begin
    res = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (!res.hit && NAME_KEYS[i] == key) begin
        res.hit  = 1'b1;
        res.code = NAME_CODES[i];
      end
    end
  end

endmodule

// File: rtl/core/hed_checker.sv
// Port-level checks on the entity decoder, bound to its top level.
`include "html_entity_decoder_defines.svh"

module hed_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser
);

  // A waiting result keeps its payload.
  `HED_ASSERT(a_out_hold,
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser),
    "result changed while stalled")

  // Reset empties the result register.
  `HED_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_tvalid, "result valid after reset")

  // A rejected reference always reads as a lone ampersand.
  `HED_ASSERT(a_reject_form,
    out_tvalid && !out_tuser |-> out_tdata[31:0] == 32'h26 && out_tdata[37:32] == 6'd1,
    "malformed reject")

  // A decoded reference spans the ampersand, the body and the semicolon.
  `HED_ASSERT(a_accept_adv,
    out_tvalid && out_tuser |-> out_tdata[37:32] >= 6'd2 && out_tdata[37:32] <= 6'd34
      && out_tdata[39:38] == 2'b00,
    "advance out of range")

endmodule

bind html_entity_decoder hed_checker u_hed_checker (.*);
